/* hdl/tlpt_pkg.sv */
// shared constants, entry layout and helpers for the page-table mapper
// no dependencies
package tlpt_pkg;

    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int IDX_W             = 10;
    localparam int FRAME_W           = 20;
    localparam int ENTRY_W           = 23;
    localparam int DEF_STORE_FRAMES  = 1024;
    localparam int IN_DATA_W         = 64;
    localparam int OUT_DATA_W        = 8;

    localparam logic [FRAME_W-1:0] FIRST_FREE_RST = 20'd256;

    // entry bit positions
    localparam int BIT_P  = 0;
    localparam int BIT_RW = 1;
    localparam int BIT_US = 2;

    localparam logic MODE_MAP   = 1'b0;
    localparam logic MODE_UNMAP = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOFREE = 2'd2
    } t_status;

    function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                     input logic user);
        return {frame, user, 1'b1, 1'b1};
    endfunction

    function automatic logic [FRAME_W-1:0] frame_of(input logic [ENTRY_W-1:0] e);
        return e[ENTRY_W-1:3];
    endfunction

endpackage

/* hdl/tlpt_store.sv */
// table store: single-write, single-read synchronous memory, registered read
// zeroing sweep after reset; depends on tlpt_pkg
module tlpt_store #(
    parameter int STORE_FRAMES = tlpt_pkg::DEF_STORE_FRAMES,
    parameter int ADDR_W       = $clog2(STORE_FRAMES) + tlpt_pkg::IDX_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    output logic [tlpt_pkg::ENTRY_W-1:0] o_rd_data,
    input  logic                         i_wr_en,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [tlpt_pkg::ENTRY_W-1:0] i_wr_data,
    output logic                         o_ready
);
    import tlpt_pkg::*;

    localparam int DEPTH = STORE_FRAMES * ENTRIES_PER_TABLE;
    localparam logic [ADDR_W:0] LAST_ADDR = (ADDR_W + 1)'(DEPTH - 1);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ADDR_W:0]    r_clr_addr;
    logic               r_clearing;

    logic               n_wr_en;
    logic [ADDR_W-1:0]  n_wr_addr;
    logic [ENTRY_W-1:0] n_wr_data;

    always_comb begin
        if (r_clearing) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_clr_addr[ADDR_W-1:0];
            n_wr_data = '0;
        end else begin
            n_wr_en   = i_wr_en;
            n_wr_addr = i_wr_addr;
            n_wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

/* hdl/two_level_page_table_mapper_unit.sv */
// two-level page-table map/unmap engine: sequencer, allocator, result register
// depends on tlpt_pkg and tlpt_store
//
//  channel | direction | handshake                    | payload
//  s       | in        | i_s_tvalid / o_s_tready      | i_s_tdata: request
//  m       | out       | o_m_tvalid / i_m_tready      | o_m_tdata: result
//  cfg     | in        | i_cfg_valid / o_cfg_ready    | i_cfg_data: first_free_frame
//
// map to a present table: directory read, check, entry write; map with a new table:
// allocate, then sweep the table, one store entry read and rewritten per cycle; unmap:
// entry read and cleared, then one entry scanned per cycle until a present one is found
// after reset the store is zeroed, no requests taken
// a stalled result holds the next request at its final step only
// cfg is taken only while idle
module two_level_page_table_mapper_unit #(
    parameter int STORE_FRAMES = tlpt_pkg::DEF_STORE_FRAMES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // mode, virtual_page, directory_frame, physical_frame, user_access
    input  logic [tlpt_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status, table_allocated, table_released
    output logic [tlpt_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tlpt_pkg::FRAME_W-1:0]    i_cfg_data
);
    import tlpt_pkg::*;

    localparam int FW     = $clog2(STORE_FRAMES);
    localparam int ADDR_W = FW + IDX_W;
    localparam logic [FRAME_W-1:0] SF_LIM = FRAME_W'(STORE_FRAMES);
    localparam logic [ENTRY_W-1:0] CLR_PU = ~(ENTRY_W'(1) << BIT_P | ENTRY_W'(1) << BIT_US);
    localparam logic [ENTRY_W-1:0] CLR_P  = ~(ENTRY_W'(1) << BIT_P);

    typedef enum logic [3:0] {
        S_IDLE, S_DIR_RD, S_DIR_CHK, S_CLR, S_MAP_WR,
        S_UN_RD, S_UN_CLR, S_SCAN, S_REL_RD, S_REL, S_DONE
    } t_state;

    t_state             r_state;
    logic               r_mode;
    logic [IDX_W-1:0]   r_dix;
    logic [IDX_W-1:0]   r_tix;
    logic [FW-1:0]      r_dir;
    logic [FRAME_W-1:0] r_phys;
    logic               r_user;
    logic [FW-1:0]      r_tf;
    logic [IDX_W:0]     r_cnt;
    logic [FRAME_W-1:0] r_next_free;
    t_status            r_status;
    logic               r_alloc;
    logic               r_rel;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_ready;

    logic [FRAME_W-1:0] in_vpage;
    logic [FRAME_W-1:0] in_dir;
    logic [FRAME_W-1:0] rd_frame;
    logic [IDX_W-1:0]   cnt_prev;

    assign in_vpage = i_s_tdata[20:1];
    assign in_dir   = i_s_tdata[40:21];
    assign rd_frame = frame_of(mem_rd_data);
    assign cnt_prev = r_cnt[IDX_W-1:0] - 1'b1;

    tlpt_store #(
        .STORE_FRAMES (STORE_FRAMES),
        .ADDR_W       (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_ready   (mem_ready)
    );

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = {r_dir, r_dix};
        mem_wr_en   = 1'b0;
        mem_wr_addr = {r_dir, r_dix};
        mem_wr_data = mem_rd_data;
        unique case (r_state)
            S_DIR_RD, S_REL_RD: begin
                mem_rd_en = 1'b1;
            end
            S_DIR_CHK: begin
                mem_wr_en   = (r_mode == MODE_MAP) && !mem_rd_data[BIT_P] &&
                              (r_next_free < SF_LIM);
                mem_wr_data = make_entry(r_next_free, r_user);
            end
            S_CLR: begin
                mem_rd_en   = !r_cnt[IDX_W];
                mem_rd_addr = {r_tf, r_cnt[IDX_W-1:0]};
                mem_wr_en   = (r_cnt != '0);
                mem_wr_addr = {r_tf, cnt_prev};
                mem_wr_data = mem_rd_data & CLR_PU;
            end
            S_MAP_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = {r_tf, r_tix};
                mem_wr_data = make_entry(r_phys, r_user);
            end
            S_UN_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = {r_tf, r_tix};
            end
            S_UN_CLR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = {r_tf, r_tix};
                mem_wr_data = mem_rd_data & CLR_PU;
            end
            S_SCAN: begin
                mem_rd_en   = !r_cnt[IDX_W];
                mem_rd_addr = {r_tf, r_cnt[IDX_W-1:0]};
            end
            S_REL: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data & CLR_P;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_next_free <= FIRST_FREE_RST;
        end else begin
            if (r_out_valid && i_m_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && o_s_tready) begin
                        r_mode   <= i_s_tdata[0];
                        r_dix    <= in_vpage[2*IDX_W-1:IDX_W];
                        r_tix    <= in_vpage[IDX_W-1:0];
                        r_dir    <= in_dir[FW-1:0];
                        r_phys   <= i_s_tdata[60:41];
                        r_user   <= i_s_tdata[61];
                        r_alloc  <= 1'b0;
                        r_rel    <= 1'b0;
                        if (in_dir >= SF_LIM) begin
                            r_status <= ST_RANGE;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_DONE;
                            r_state  <= S_DIR_RD;
                        end
                    end
                end
                S_DIR_RD: begin
                    r_state <= S_DIR_CHK;
                end
                S_DIR_CHK: begin
                    r_cnt <= '0;
                    if (r_mode == MODE_MAP && !mem_rd_data[BIT_P]) begin
                        if (r_next_free >= SF_LIM) begin
                            r_status <= ST_NOFREE;
                            r_state  <= S_DONE;
                        end else begin
                            r_tf        <= r_next_free[FW-1:0];
                            r_next_free <= r_next_free + 1'b1;
                            r_alloc     <= 1'b1;
                            r_state     <= S_CLR;
                        end
                    end else if (rd_frame >= SF_LIM) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_tf    <= rd_frame[FW-1:0];
                        r_state <= (r_mode == MODE_MAP) ? S_MAP_WR : S_UN_RD;
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[IDX_W]) begin
                        r_state <= S_MAP_WR;
                    end
                end
                S_MAP_WR: begin
                    r_state <= S_DONE;
                end
                S_UN_RD: begin
                    r_state <= S_UN_CLR;
                end
                S_UN_CLR: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != '0 && mem_rd_data[BIT_P]) begin
                        r_state <= S_DONE;
                    end else if (r_cnt[IDX_W]) begin
                        r_state <= S_REL_RD;
                    end
                end
                S_REL_RD: begin
                    r_state <= S_REL;
                end
                S_REL: begin
                    r_rel   <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'b0, r_rel, r_alloc, r_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_valid && o_cfg_ready) begin
                r_next_free <= i_cfg_data;
            end
        end
    end

    assign o_s_tready  = (r_state == S_IDLE) && mem_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = (r_state == S_IDLE);

endmodule

/* hdl/tlpt_checker.sv */
// port-level checks for the page-table mapper, bound to the top level
// depends on two_level_page_table_mapper_unit and tlpt_pkg
module tlpt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [tlpt_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [tlpt_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [tlpt_pkg::FRAME_W-1:0]    i_cfg_data
);
    import tlpt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_err_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != ST_DONE |-> o_m_tdata[3:2] == 2'b00)
        else $error("flags set on error status");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[2] && o_m_tdata[3]))
        else $error("allocated and released together");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while previous one in work");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("outputs active after reset");

endmodule

bind two_level_page_table_mapper_unit tlpt_checker u_tlpt_checker (.*);
